/* src/abbt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abbt_pkg
// Shared types, constants and the rounding function of the affine bounding
// box transform.
// ----------------------------------------------------------------------------
package abbt_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int COEF_FRAC_BITS  = 16;

    localparam int WORD_W   = 32;
    localparam int PROD_W   = 2 * WORD_W;
    localparam int FRAC_SUM = COORD_FRAC_BITS + COEF_FRAC_BITS;
    // Two products plus a shifted offset fit in 65 bits; the extra room keeps the
    // integer part at least 34 bits wide whatever the fraction widths are.
    localparam int SUM_W    = (FRAC_SUM + 34 > 66) ? (FRAC_SUM + 34) : 66;
    localparam int INT_W    = SUM_W - FRAC_SUM;
    localparam int IDX_W    = 3;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [INT_W:0]    rnd_t;

    typedef enum logic [IDX_W-1:0] {
        REG_COEF_XX  = 3'd0,
        REG_COEF_XY  = 3'd1,
        REG_OFFSET_X = 3'd2,
        REG_COEF_YX  = 3'd3,
        REG_COEF_YY  = 3'd4,
        REG_OFFSET_Y = 3'd5
    } reg_idx_t;

    localparam word_t COEF_ONE = word_t'(1) <<< COEF_FRAC_BITS;

    localparam rnd_t SAT_HI = rnd_t'(word_t'(32'sh7FFF_FFFF));
    localparam rnd_t SAT_LO = ~SAT_HI;

    // Load enables of the four pipeline stages.
    typedef struct packed {
        logic s1_en;
        logic s2_en;
        logic s3_en;
        logic s4_en;
    } pipe_ctrl_t;

    // Drops all fraction bits rounding away from zero, then saturates to 32 bits.
    function automatic word_t round_sat(input sum_t v);
        logic neg;
        logic frac_nz;
        rnd_t q;
        neg     = v[SUM_W-1];
        frac_nz = |v[FRAC_SUM-1:0];
        q = $signed({v[SUM_W-1], v[SUM_W-1:FRAC_SUM]})
            + $signed({{INT_W{1'b0}}, (~neg & frac_nz)});
        if (q > SAT_HI)
        begin
            q = SAT_HI;
        end
        if (q < SAT_LO)
        begin
            q = SAT_LO;
        end
        return q[WORD_W-1:0];
    endfunction

endpackage

/* src/abbt_axis.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abbt_axis
// Four-stage datapath for one output axis: the least and greatest value of
// u*x + v*y + offset over the corners of a rectangle.
// ----------------------------------------------------------------------------
module abbt_axis (
    input  logic                clk,
    input  abbt_pkg::pipe_ctrl_t ctrl,
    input  abbt_pkg::word_t     coef_u,
    input  abbt_pkg::word_t     coef_v,
    input  abbt_pkg::word_t     offset,
    input  abbt_pkg::word_t     x0,
    input  abbt_pkg::word_t     x1,
    input  abbt_pkg::word_t     y0,
    input  abbt_pkg::word_t     y1,
    output abbt_pkg::word_t     lo,
    output abbt_pkg::word_t     hi
);
    import abbt_pkg::*;

    prod_t pu0_reg, pu1_reg, pv0_reg, pv1_reg;
    prod_t u_lo_reg, u_hi_reg, v_lo_reg, v_hi_reg;
    prod_t u_lo_next, u_hi_next, v_lo_next, v_hi_next;
    sum_t  sum_lo_reg, sum_hi_reg;
    sum_t  sum_lo_next, sum_hi_next;
    word_t lo_reg, hi_reg;

    // The x and y terms vary independently over the corners, so the extreme
    // of the sum is the sum of the extremes of each term.
    always_comb
    begin
        if (pu0_reg < pu1_reg)
        begin
            u_lo_next = pu0_reg;
            u_hi_next = pu1_reg;
        end
        else
        begin
            u_lo_next = pu1_reg;
            u_hi_next = pu0_reg;
        end
        if (pv0_reg < pv1_reg)
        begin
            v_lo_next = pv0_reg;
            v_hi_next = pv1_reg;
        end
        else
        begin
            v_lo_next = pv1_reg;
            v_hi_next = pv0_reg;
        end
        sum_lo_next = sum_t'(u_lo_reg) + sum_t'(v_lo_reg)
                      + (sum_t'(offset) <<< COORD_FRAC_BITS);
        sum_hi_next = sum_t'(u_hi_reg) + sum_t'(v_hi_reg)
                      + (sum_t'(offset) <<< COORD_FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s1_en)
        begin
            pu0_reg <= prod_t'(coef_u) * prod_t'(x0);
            pu1_reg <= prod_t'(coef_u) * prod_t'(x1);
            pv0_reg <= prod_t'(coef_v) * prod_t'(y0);
            pv1_reg <= prod_t'(coef_v) * prod_t'(y1);
        end
        if (ctrl.s2_en)
        begin
            u_lo_reg <= u_lo_next;
            u_hi_reg <= u_hi_next;
            v_lo_reg <= v_lo_next;
            v_hi_reg <= v_hi_next;
        end
        if (ctrl.s3_en)
        begin
            sum_lo_reg <= sum_lo_next;
            sum_hi_reg <= sum_hi_next;
        end
        if (ctrl.s4_en)
        begin
            lo_reg <= round_sat(sum_lo_reg);
            hi_reg <= round_sat(sum_hi_reg);
        end
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

/* src/affine_bounding_box_transform.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_bounding_box_transform
// Maps an axis-aligned Q16.16 rectangle through a 2x3 affine matrix and
// returns its integer bounding box, rounded away from zero and saturated.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake              | Word
//  --------+------------------------+---------------------------------------
//  in      | in_valid / in_ready    | left_in, top_in, right_in, bottom_in
//  out     | out_valid / out_ready  | left_out, top_out, right_out, bottom_out
//  cfg     | cfg_wr_en (no wait)    | cfg_index, cfg_data
//
// One word is accepted every cycle while in_ready is high. The edge that takes
// an input word loads the first of four stages (multiply, pick extremes, add,
// then round and saturate), and its result is presented from the last stage.
// The rate is set by the eight 32x32 multipliers in the first stage, one per
// product, so no unit is shared between words.
// Reset clears the stage valid bits and loads the identity matrix.
// A stall at the output only holds the stages that are full; empty stages
// behind it keep filling, so up to four words wait in flight without loss.
// ----------------------------------------------------------------------------
module affine_bounding_box_transform (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [abbt_pkg::IDX_W-1:0]    cfg_index,
    input  abbt_pkg::word_t               cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  abbt_pkg::word_t               left_in,
    input  abbt_pkg::word_t               top_in,
    input  abbt_pkg::word_t               right_in,
    input  abbt_pkg::word_t               bottom_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output abbt_pkg::word_t               left_out,
    output abbt_pkg::word_t               top_out,
    output abbt_pkg::word_t               right_out,
    output abbt_pkg::word_t               bottom_out
);
    import abbt_pkg::*;

    // Matrix registers, read directly by whatever stage needs them. The user must
    // change them only while no word is in flight; the block does not enforce it.
    word_t coef_xx_reg, coef_xy_reg, offset_x_reg;
    word_t coef_yx_reg, coef_yy_reg, offset_y_reg;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready;
    pipe_ctrl_t ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_xx_reg  <= COEF_ONE;
            coef_xy_reg  <= '0;
            offset_x_reg <= '0;
            coef_yx_reg  <= '0;
            coef_yy_reg  <= COEF_ONE;
            offset_y_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            // Indexes past the last register are dropped.
            case (reg_idx_t'(cfg_index))
                REG_COEF_XX:  coef_xx_reg  <= cfg_data;
                REG_COEF_XY:  coef_xy_reg  <= cfg_data;
                REG_OFFSET_X: offset_x_reg <= cfg_data;
                REG_COEF_YX:  coef_yx_reg  <= cfg_data;
                REG_COEF_YY:  coef_yy_reg  <= cfg_data;
                REG_OFFSET_Y: offset_y_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // A stage may load when it is empty or when its content moves on in the
    // same cycle. The chain runs back from the output handshake.
    assign s4_ready = ~s4_valid_reg | out_ready;
    assign s3_ready = ~s3_valid_reg | s4_ready;
    assign s2_ready = ~s2_valid_reg | s3_ready;
    assign s1_ready = ~s1_valid_reg | s2_ready;

    assign ctrl.s1_en = s1_ready;
    assign ctrl.s2_en = s2_ready;
    assign ctrl.s3_en = s3_ready;
    assign ctrl.s4_en = s4_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Output x uses the x weights; the corners come from left/right and
    // top/bottom in both lanes.
    abbt_axis u_axis_x (
        .clk    (clk),
        .ctrl   (ctrl),
        .coef_u (coef_xx_reg),
        .coef_v (coef_xy_reg),
        .offset (offset_x_reg),
        .x0     (left_in),
        .x1     (right_in),
        .y0     (top_in),
        .y1     (bottom_in),
        .lo     (left_out),
        .hi     (right_out)
    );

    abbt_axis u_axis_y (
        .clk    (clk),
        .ctrl   (ctrl),
        .coef_u (coef_yx_reg),
        .coef_v (coef_yy_reg),
        .offset (offset_y_reg),
        .x0     (left_in),
        .x1     (right_in),
        .y0     (top_in),
        .y1     (bottom_in),
        .lo     (top_out),
        .hi     (bottom_out)
    );

    assign in_ready  = s1_ready;
    assign out_valid = s4_valid_reg;

endmodule
